// ===== sv/tsig_pkg.sv =====
// Shared types and constants for the trapezoid step interval generator.
// No dependencies; imported by trapezoid_step_interval_generator.
package tsig_pkg;

    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 20;
    localparam int SPEED_W       = 16;
    localparam int ACCEL_W       = 20;
    localparam int STEPS_W       = 17;
    localparam int COUNT_W       = 16;
    localparam int DELAY_W       = 20;
    localparam int RADICAND_W    = 38;
    localparam int REM_W         = 22;
    localparam int QUO_W         = 32;
    localparam int ROOT_W        = 19;
    localparam int ITER_W        = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_CRUISE_SPEED = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCELERATION = 8'd1;

    localparam logic [SPEED_W-1:0] CRUISE_SPEED_RESET = 16'd3000;
    localparam logic [ACCEL_W-1:0] ACCELERATION_RESET = 20'd5000;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [QUO_W-1:0]      BASE_SPEED_SQ  = 32'd10000;
    localparam logic [DELAY_W-1:0]    MICROS_PER_SEC = 20'd1000000;

    localparam logic [ITER_W-1:0] RAMP_DIV_LAST  = 5'd31;
    localparam logic [ITER_W-1:0] DELAY_DIV_LAST = 5'd19;
    localparam logic [ITER_W-1:0] SQRT_LAST      = 5'd18;

endpackage

// ===== sv/trapezoid_step_interval_generator.sv =====
// Trapezoidal motion profile step interval generator, top level.
// Depends on tsig_pkg for widths, register indexes and constants.
//
// A start beat (tuser 0) latches a signed step count and computes the ramp
// length with a restoring divider. A step beat (tuser 1) returns the
// direction, the microsecond delay after the pulse and a last-step flag.
// Ramp steps take one multiply, a square root and a divide; cruise steps
// skip the multiply and the root. A single shared subtract-and-compare unit
// performs every root and divide iteration, so one beat is in work at a
// time. The result sits in an output register, and the block stalls only
// when that register is still full and not being taken as the next result
// is ready.
module trapezoid_step_interval_generator (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tsig_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [tsig_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [23:0]                            s_tdata,  // [16:0] move_steps
    input  logic                                   s_tuser,  // [0] cmd
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [23:0]                            m_tdata,  // [0] direction, [20:1] wait_us
    output logic                                   m_tlast   // last_step
);
    import tsig_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RMUL, S_RPREP, S_RDIV, S_RCLAMP,
        S_SMUL, S_SPREP, S_SQRT, S_DPREP, S_DIV, S_OUT
    } state_t;

    state_t                  state_reg;
    logic [SPEED_W-1:0]      cruise_reg;
    logic [ACCEL_W-1:0]      accel_reg;
    logic                    active_reg;
    logic                    dir_reg;
    logic [COUNT_W-1:0]      len_reg;
    logic [COUNT_W-1:0]      idx_reg;
    logic [COUNT_W-1:0]      ramp_reg;
    logic [COUNT_W-1:0]      term_reg;
    logic                    last_reg;
    logic [35:0]             prod_reg;
    logic [RADICAND_W-1:0]   num_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [QUO_W-1:0]        quo_reg;
    logic [REM_W-2:0]        den_reg;
    logic [ROOT_W-1:0]       spd_reg;
    logic [ITER_W-1:0]       cnt_reg;
    logic                    m_valid_reg;
    logic                    m_dir_reg;
    logic [DELAY_W-1:0]      m_delay_reg;
    logic                    m_last_reg;

    logic [ACCEL_W-1:0]      eff_accel;
    logic [ACCEL_W-1:0]      mul_a;
    logic [COUNT_W-1:0]      mul_b;
    logic [35:0]             mul_p;
    logic                    sqrt_mode;
    logic [REM_W-1:0]        sub_a;
    logic [REM_W-1:0]        sub_b;
    logic [REM_W:0]          diff;
    logic                    ge;
    logic [STEPS_W-1:0]      raw;
    logic [STEPS_W-1:0]      mag17;
    logic [COUNT_W-1:0]      mag;
    logic [COUNT_W-1:0]      half_len;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {3'b000, m_delay_reg, m_dir_reg};
    assign m_tlast   = m_last_reg;

    assign eff_accel = (accel_reg == '0) ? {{(ACCEL_W-1){1'b0}}, 1'b1} : accel_reg;
    assign mul_a     = (state_reg == S_RMUL) ? {4'b0000, cruise_reg} : eff_accel;
    assign mul_b     = (state_reg == S_RMUL) ? cruise_reg : term_reg;
    assign mul_p     = {16'd0, mul_a} * {20'd0, mul_b};

    assign sqrt_mode = (state_reg == S_SQRT);
    always_comb begin
        if (sqrt_mode) begin
            sub_a = {rem_reg[REM_W-3:0], num_reg[RADICAND_W-1 -: 2]};
            sub_b = {quo_reg[REM_W-3:0], 2'b01};
        end else begin
            sub_a = {rem_reg[REM_W-2:0], num_reg[RADICAND_W-1]};
            sub_b = {1'b0, den_reg};
        end
    end
    assign diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge   = ~diff[REM_W];

    assign raw      = s_tdata[STEPS_W-1:0];
    assign mag17    = raw[STEPS_W-1] ? (~raw + 17'd1) : raw;
    assign mag      = mag17[STEPS_W-1] ? 16'hFFFF : mag17[COUNT_W-1:0];
    assign half_len = {1'b0, len_reg[COUNT_W-1:1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cruise_reg  <= CRUISE_SPEED_RESET;
            accel_reg   <= ACCELERATION_RESET;
            active_reg  <= 1'b0;
            dir_reg     <= 1'b0;
            len_reg     <= '0;
            idx_reg     <= '0;
            ramp_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_CRUISE_SPEED: cruise_reg <= cfg_data[SPEED_W-1:0];
                    REG_ACCELERATION: accel_reg  <= cfg_data[ACCEL_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser == CMD_START) begin
                            if (mag == '0) begin
                                active_reg <= 1'b0;
                            end else begin
                                dir_reg    <= ~raw[STEPS_W-1];
                                len_reg    <= mag;
                                idx_reg    <= '0;
                                active_reg <= 1'b1;
                                state_reg  <= S_RMUL;
                            end
                        end else if (active_reg) begin
                            last_reg <= ({1'b0, idx_reg} + 17'd1) >= {1'b0, len_reg};
                            if (({1'b0, idx_reg} + 17'd1) >= {1'b0, len_reg}) begin
                                active_reg <= 1'b0;
                            end
                            idx_reg <= idx_reg + 16'd1;
                            if (idx_reg < ramp_reg) begin
                                term_reg  <= idx_reg;
                                state_reg <= S_SMUL;
                            end else if (idx_reg >= len_reg - ramp_reg) begin
                                term_reg  <= len_reg - 16'd1 - idx_reg;
                                state_reg <= S_SMUL;
                            end else begin
                                spd_reg   <= (cruise_reg == '0) ? 19'd1 : {3'b000, cruise_reg};
                                state_reg <= S_DPREP;
                            end
                        end
                    end
                end
                S_RMUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_RPREP;
                end
                S_RPREP: begin
                    rem_reg <= '0;
                    quo_reg <= '0;
                    den_reg <= {eff_accel, 1'b0};
                    cnt_reg <= RAMP_DIV_LAST;
                    num_reg <= {prod_reg[QUO_W-1:0] - BASE_SPEED_SQ, 6'd0};
                    if (prod_reg[QUO_W-1:0] > BASE_SPEED_SQ) begin
                        state_reg <= S_RDIV;
                    end else begin
                        state_reg <= S_RCLAMP;
                    end
                end
                S_RDIV, S_DIV: begin
                    rem_reg <= ge ? diff[REM_W-1:0] : sub_a;
                    quo_reg <= {quo_reg[QUO_W-2:0], ge};
                    num_reg <= {num_reg[RADICAND_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == '0) begin
                        state_reg <= (state_reg == S_RDIV) ? S_RCLAMP : S_OUT;
                    end
                end
                S_RCLAMP: begin
                    if (quo_reg > {16'd0, half_len}) begin
                        ramp_reg <= half_len;
                    end else begin
                        ramp_reg <= quo_reg[COUNT_W-1:0];
                    end
                    state_reg <= S_IDLE;
                end
                S_SMUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_SPREP;
                end
                S_SPREP: begin
                    num_reg   <= {6'd0, BASE_SPEED_SQ} + {1'b0, prod_reg, 1'b0};
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= SQRT_LAST;
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    rem_reg <= ge ? diff[REM_W-1:0] : sub_a;
                    quo_reg <= {quo_reg[QUO_W-2:0], ge};
                    num_reg <= {num_reg[RADICAND_W-3:0], 2'b00};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == '0) begin
                        spd_reg   <= {quo_reg[ROOT_W-2:0], ge};
                        state_reg <= S_DPREP;
                    end
                end
                S_DPREP: begin
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    den_reg   <= {2'b00, spd_reg};
                    num_reg   <= {MICROS_PER_SEC, 18'd0};
                    cnt_reg   <= DELAY_DIV_LAST;
                    state_reg <= S_DIV;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_dir_reg   <= dir_reg;
                        m_delay_reg <= quo_reg[DELAY_W-1:0];
                        m_last_reg  <= last_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
